### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### rtl/p2i_pkg.sv
// package for the perifocal to inertial rotation block
// constants, arctangent table and quadrant codes; no dependencies
`default_nettype none
package p2i_pkg;
	localparam int ANGLE_BITS_DEF = 24;
	localparam int VECTOR_BITS_DEF = 48;
	localparam int COEF_BITS_DEF = 32;
	localparam int CORDIC_FRAC = 40;
	localparam int CORDIC_STEPS = 32;
	localparam int CW = 44;
	localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 44'sd667681663043;

	typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

	function automatic logic signed [32:0] atan_turn(input int k);
		logic signed [32:0] t;
		case (k)
			0: t = 33'sh20000000;  1: t = 33'sh12E4051E;
			2: t = 33'sh09FB385B;  3: t = 33'sh051111D4;
			4: t = 33'sh028B0D43;  5: t = 33'sh0145D7E1;
			6: t = 33'sh00A2F61E;  7: t = 33'sh00517C55;
			8: t = 33'sh0028BE53;  9: t = 33'sh00145F2F;
			10: t = 33'sh000A2F98; 11: t = 33'sh000517CC;
			12: t = 33'sh00028BE6; 13: t = 33'sh000145F3;
			14: t = 33'sh0000A2FA; 15: t = 33'sh0000517D;
			16: t = 33'sh000028BE; 17: t = 33'sh0000145F;
			18: t = 33'sh00000A30; 19: t = 33'sh00000518;
			20: t = 33'sh0000028C; 21: t = 33'sh00000146;
			22: t = 33'sh000000A3; 23: t = 33'sh00000051;
			24: t = 33'sh00000029; 25: t = 33'sh00000014;
			26: t = 33'sh0000000A; 27: t = 33'sh00000005;
			28: t = 33'sh00000003; 29: t = 33'sh00000001;
			30: t = 33'sh00000001;
			default: t = 33'sh0;
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

### rtl/p2i_cordic.sv
// pipelined rotation cordic: binary angle in, rounded q1.cf cosine and sine out
// uses p2i_pkg; advances when en is high, four micro-rotations per stage
`default_nettype none
module p2i_cordic #(
	parameter int ANGLE_BITS = p2i_pkg::ANGLE_BITS_DEF,
	parameter int COEF_BITS = p2i_pkg::COEF_BITS_DEF
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [ANGLE_BITS-1:0] angle,
	output logic signed [COEF_BITS-1:0] cos_out,
	output logic signed [COEF_BITS-1:0] sin_out
);
	localparam int CW = p2i_pkg::CW;
	localparam int N = p2i_pkg::CORDIC_STEPS;
	localparam int CF = COEF_BITS - 2;
	localparam int SH = p2i_pkg::CORDIC_FRAC - CF;
	localparam int PER = 4;
	localparam int NST = N / PER;

	logic signed [CW-1:0] x_s [NST+1];
	logic signed [CW-1:0] y_s [NST+1];
	logic signed [32:0] z_s [NST+1];
	p2i_pkg::quad_t q_s [NST+1];

	logic [31:0] a32;
	logic [31:0] rem;
	logic [1:0] q0;

	always_comb begin
		a32 = 32'(angle) << (32 - ANGLE_BITS);
		q0 = 2'((a32 + 32'h2000_0000) >> 30);
		rem = a32 - {q0, 30'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= p2i_pkg::CORDIC_GAIN_INV;
			y_s[0] <= '0;
			z_s[0] <= 33'(signed'(rem));
			q_s[0] <= p2i_pkg::quad_t'(q0);
		end
	end

	for (genvar g = 0; g < NST; g++) begin : g_st
		logic signed [CW-1:0] xv [PER+1];
		logic signed [CW-1:0] yv [PER+1];
		logic signed [32:0] zv [PER+1];
		always_comb begin
			xv[0] = x_s[g];
			yv[0] = y_s[g];
			zv[0] = z_s[g];
			for (int j = 0; j < PER; j++) begin
				if (!zv[j][32]) begin
					xv[j+1] = xv[j] - (yv[j] >>> (g*PER+j));
					yv[j+1] = yv[j] + (xv[j] >>> (g*PER+j));
					zv[j+1] = zv[j] - p2i_pkg::atan_turn(g*PER+j);
				end else begin
					xv[j+1] = xv[j] + (yv[j] >>> (g*PER+j));
					yv[j+1] = yv[j] - (xv[j] >>> (g*PER+j));
					zv[j+1] = zv[j] + p2i_pkg::atan_turn(g*PER+j);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g+1] <= xv[PER];
				y_s[g+1] <= yv[PER];
				z_s[g+1] <= zv[PER];
				q_s[g+1] <= q_s[g];
			end
		end
	end

	function automatic logic signed [COEF_BITS-1:0] rnd(input logic signed [CW-1:0] v);
		logic signed [CW:0] r;
		logic signed [CW:0] one;
		one = (CW+1)'(1) <<< CF;
		r = ((CW+1)'(v) + ((CW+1)'(1) <<< (SH-1))) >>> SH;
		if (r > one) r = one;
		if (r < -one) r = -one;
		return COEF_BITS'(r);
	endfunction

	logic signed [COEF_BITS-1:0] c, s;
	always_comb begin
		c = rnd(x_s[NST]);
		s = rnd(y_s[NST]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[NST])
				p2i_pkg::QUAD_0: begin cos_out <= c; sin_out <= s; end
				p2i_pkg::QUAD_1: begin cos_out <= -s; sin_out <= c; end
				p2i_pkg::QUAD_2: begin cos_out <= -c; sin_out <= -s; end
				default: begin cos_out <= s; sin_out <= -c; end
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/perifocal_to_inertial_rotation.sv
// top level of the perifocal to inertial rotation block
// uses p2i_pkg, p2i_cordic and assert_macros.svh
//
// usage: one request on the input channel carries three binary angles
// (inclination, node, perigee) and a signed q31.16 perifocal vector.
// one result per request leaves on the output channel: the inertial vector
// r = rz(node) * rx(incl) * rz(perigee) * p, rounded and saturated.
// both channels use valid/stall; a request moves when valid is high and
// stall is low.
// pipeline stages from accept to output valid: cordic 10 stages, three
// stages of coefficient products, four for the vector multiply and sum.
// throughput: one request per cycle; the whole pipeline advances as one
// unit and freezes while the output is valid and stalled, so a stall
// neither loses nor repeats a request. in_stall follows out_stall only in
// that case (empty output register lets new requests in).
// reset clears all valid bits; payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module perifocal_to_inertial_rotation #(
	parameter int ANGLE_BITS = p2i_pkg::ANGLE_BITS_DEF,
	parameter int VECTOR_BITS = p2i_pkg::VECTOR_BITS_DEF,
	parameter int COEF_BITS = p2i_pkg::COEF_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [ANGLE_BITS-1:0] inclination,
	input wire logic [ANGLE_BITS-1:0] node_angle,
	input wire logic [ANGLE_BITS-1:0] perigee_angle,
	input wire logic signed [VECTOR_BITS-1:0] perifocal_x,
	input wire logic signed [VECTOR_BITS-1:0] perifocal_y,
	input wire logic signed [VECTOR_BITS-1:0] perifocal_z,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [VECTOR_BITS-1:0] inertial_x,
	output logic signed [VECTOR_BITS-1:0] inertial_y,
	output logic signed [VECTOR_BITS-1:0] inertial_z
);
	localparam int CB = COEF_BITS;
	localparam int CF = CB - 2;
	localparam int VB = VECTOR_BITS;
	// cordic stages: input reg + 8 rotation groups + output reg
	localparam int CLAT = p2i_pkg::CORDIC_STEPS / 4 + 2;
	localparam int LAT = CLAT + 7;
	localparam int PW = CB + VB;      // product width
	localparam int AW = PW + 2;       // sum of three products

	// whole pipe advances together; holds only when the output is stalled
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT-1];

	// trig for the three angles
	logic signed [CB-1:0] ci, si, cn, sn, cp, sp;
	p2i_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(CB)) u_cor_i (
		.clk(clk), .en(adv), .angle(inclination), .cos_out(ci), .sin_out(si));
	p2i_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(CB)) u_cor_n (
		.clk(clk), .en(adv), .angle(node_angle), .cos_out(cn), .sin_out(sn));
	p2i_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(CB)) u_cor_p (
		.clk(clk), .en(adv), .angle(perigee_angle), .cos_out(cp), .sin_out(sp));

	// vector delay line to line up with the matrix
	logic signed [VB-1:0] vx_d [CLAT+3];
	logic signed [VB-1:0] vy_d [CLAT+3];
	logic signed [VB-1:0] vz_d [CLAT+3];
	always_ff @(posedge clk) begin
		if (adv) begin
			vx_d[0] <= perifocal_x;
			vy_d[0] <= perifocal_y;
			vz_d[0] <= perifocal_z;
			for (int k = 1; k < CLAT + 3; k++) begin
				vx_d[k] <= vx_d[k-1];
				vy_d[k] <= vy_d[k-1];
				vz_d[k] <= vz_d[k-1];
			end
		end
	end

	// q1.cf product rounded half up; the rounded result is registered by caller
	function automatic logic signed [CB-1:0] cmul(input logic signed [CB-1:0] a,
		input logic signed [CB-1:0] b);
		logic signed [2*CB-1:0] p;
		p = (2*CB)'(a) * (2*CB)'(b);
		p = (p + ((2*CB)'(1) <<< (CF - 1))) >>> CF;
		return CB'(p);
	endfunction

	// coefficient stage 1: two-factor products
	logic signed [CB-1:0] cncp_s1, cnsp_s1, sncp_s1, snsp_s1, snsi_s1, cnsi_s1;
	logic signed [CB-1:0] sisp_s1, sicp_s1, ci_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			cncp_s1 <= cmul(cn, cp); cnsp_s1 <= cmul(cn, sp);
			sncp_s1 <= cmul(sn, cp); snsp_s1 <= cmul(sn, sp);
			snsi_s1 <= cmul(sn, si); cnsi_s1 <= cmul(cn, si);
			sisp_s1 <= cmul(si, sp); sicp_s1 <= cmul(si, cp);
			ci_s1 <= ci;
		end
	end

	// coefficient stage 2: third factor
	logic signed [CB-1:0] a_s2, b_s2, c_s2, d_s2;
	logic signed [CB-1:0] cncp_s2, cnsp_s2, sncp_s2, snsp_s2, snsi_s2, cnsi_s2;
	logic signed [CB-1:0] sisp_s2, sicp_s2, ci_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2 <= cmul(snsp_s1, ci_s1);
			b_s2 <= cmul(sncp_s1, ci_s1);
			c_s2 <= cmul(cnsp_s1, ci_s1);
			d_s2 <= cmul(cncp_s1, ci_s1);
			cncp_s2 <= cncp_s1; cnsp_s2 <= cnsp_s1; sncp_s2 <= sncp_s1;
			snsp_s2 <= snsp_s1; snsi_s2 <= snsi_s1; cnsi_s2 <= cnsi_s1;
			sisp_s2 <= sisp_s1; sicp_s2 <= sicp_s1; ci_s2 <= ci_s1;
		end
	end

	// coefficient stage 3: matrix entries (sums wrap at cb bits)
	logic signed [CB-1:0] m_s3 [3][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3[0][0] <= cncp_s2 - a_s2;
			m_s3[0][1] <= -cnsp_s2 - b_s2;
			m_s3[0][2] <= snsi_s2;
			m_s3[1][0] <= sncp_s2 + c_s2;
			m_s3[1][1] <= -snsp_s2 + d_s2;
			m_s3[1][2] <= -cnsi_s2;
			m_s3[2][0] <= sisp_s2;
			m_s3[2][1] <= sicp_s2;
			m_s3[2][2] <= ci_s2;
		end
	end

	// vector stage 1: split each product into two halves of the vector
	localparam int HL = VB / 2;
	localparam int HH = VB - HL;
	logic signed [CB+HH:0] ph_s4 [3][3];
	logic signed [CB+HL:0] pl_s4 [3][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					logic signed [VB-1:0] v;
					v = (c == 0) ? vx_d[CLAT+2] : (c == 1) ? vy_d[CLAT+2] : vz_d[CLAT+2];
					ph_s4[r][c] <= (CB+HH+1)'(m_s3[r][c]) *
						(CB+HH+1)'(signed'(v[VB-1:HL]));
					pl_s4[r][c] <= (CB+HL+1)'(m_s3[r][c]) *
						(CB+HL+1)'(signed'({1'b0, v[HL-1:0]}));
				end
			end
		end
	end

	// vector stage 2: recombine halves
	logic signed [PW-1:0] p_s5 [3][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					p_s5[r][c] <= (PW'(ph_s4[r][c]) <<< HL) + PW'(pl_s4[r][c]);
				end
			end
		end
	end

	// vector stage 3: row sums
	logic signed [AW-1:0] acc_s6 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				acc_s6[r] <= AW'(p_s5[r][0]) + AW'(p_s5[r][1]) + AW'(p_s5[r][2]);
			end
		end
	end

	// vector stage 4: round and saturate into the output register
	function automatic logic signed [VB-1:0] sat(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] t;
		logic signed [AW-1:0] hi;
		logic signed [AW-1:0] lo;
		hi = AW'({1'b0, {(VB-1){1'b1}}});
		lo = -hi - AW'(1);
		t = (a + (AW'(1) <<< (CF - 1))) >>> CF;
		if (t > hi) return {1'b0, {(VB-1){1'b1}}};
		if (t < lo) return {1'b1, {(VB-1){1'b0}}};
		return VB'(t);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			inertial_x <= sat(acc_s6[0]);
			inertial_y <= sat(acc_s6[1]);
			inertial_z <= sat(acc_s6[2]);
		end
	end

	`ASSERT_IMPLY(a_stall_only_full, clk, arst_n, in_stall, out_valid && out_stall,
		"input stalled without a stalled result")
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && out_stall, out_valid,
		"stalled result dropped")
	`ASSERT_NEXT(a_pipe_flow, clk, arst_n, !in_stall && in_valid, vld_q[0],
		"accepted request not tracked")
endmodule
`default_nettype wire
